// ===== rtl/core/parl_pkg.sv =====
// Shared types and constants for the phase adaptive RRIP/LFU replacement block.
// Used by parl_scan and phase_adaptive_rrip_lfu_replacement; no dependencies.
`timescale 1ns / 1ps

package parl_pkg;

    // Geometry and policy constants
    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int WINDOW_LEN  = 32;
    localparam int REUSE_LIMIT = 7;
    localparam int REREF_BITS  = 2;

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int RU_W      = $clog2(REUSE_LIMIT + 1);
    localparam int MIN_W     = $clog2(REUSE_LIMIT + 2);
    localparam int POS_W     = $clog2(WINDOW_LEN);
    localparam int HIT_W     = $clog2(WINDOW_LEN + 1);
    localparam int THR_W     = 6;
    localparam int HALF_WAYS = NUM_WAYS / 2;

    localparam logic [REREF_BITS-1:0] REREF_MAX = {REREF_BITS{1'b1}};
    localparam logic [THR_W-1:0]      THR_RESET = THR_W'(16);

    // Operation codes
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Per-way replacement state
    typedef struct packed {
        logic [REREF_BITS-1:0] rr;
        logic [RU_W-1:0]       ru;
    } way_state_t;

    // One memory row: per-set window state plus all ways
    typedef struct packed {
        logic                         high_reuse;
        logic [HIT_W-1:0]             hits;
        logic [POS_W-1:0]             pos;
        way_state_t [NUM_WAYS-1:0]    ways;
    } set_row_t;

    // Running state of the victim scan
    typedef struct packed {
        logic [REREF_BITS-1:0] max_rr;
        logic [MIN_W-1:0]      min_ru;
        logic [WAY_W-1:0]      victim;
    } scan_carry_t;

    localparam scan_carry_t SCAN_INIT = '{
        max_rr: '0,
        min_ru: MIN_W'(REUSE_LIMIT + 1),
        victim: '0
    };

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN
    } state_t;

    // Row contents after reset
    function automatic set_row_t reset_row();
        set_row_t r;
        r.high_reuse = 1'b1;
        r.hits       = '0;
        r.pos        = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            r.ways[i].rr = REREF_MAX;
            r.ways[i].ru = '0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/parl_scan.sv =====
// Ordered victim scan over half of the ways of one set.
// Depends on parl_pkg for way state and scan carry types.
`timescale 1ns / 1ps

module parl_scan (
    input  logic                                        high_reuse,
    input  parl_pkg::scan_carry_t                       carry_in,
    input  parl_pkg::way_state_t [parl_pkg::HALF_WAYS-1:0] ways,
    input  logic [parl_pkg::WAY_W-1:0]                  base,
    output parl_pkg::scan_carry_t                       carry_out
);

    // Walk the ways in order, letting each way that wins the comparison take over the running choice
    always_comb
    begin
        parl_pkg::scan_carry_t          c;
        logic                           take;
        logic [parl_pkg::REREF_BITS-1:0] rr;
        logic [parl_pkg::MIN_W-1:0]     ru;
        c = carry_in;
        for (int i = 0; i < parl_pkg::HALF_WAYS; i++)
        begin
            rr = ways[i].rr;
            ru = parl_pkg::MIN_W'(ways[i].ru);
            if (high_reuse)
            begin
                take = (rr >= c.max_rr) &&
                       ((ru < c.min_ru) || ((ru == c.min_ru) && (rr > c.max_rr)));
            end
            else
            begin
                take = (ru <= c.min_ru) &&
                       ((rr > c.max_rr) || ((rr == c.max_rr) && (ru < c.min_ru)));
            end
            if (take)
            begin
                c.victim = base + parl_pkg::WAY_W'(i);
                c.max_rr = rr;
                c.min_ru = ru;
            end
        end
        carry_out = c;
    end

endmodule

// ===== rtl/core/phase_adaptive_rrip_lfu_replacement.sv =====
// Phase adaptive RRIP/LFU replacement policy, 2048 sets of 16 ways, one row per set.
// Depends on parl_pkg and parl_scan.
`timescale 1ns / 1ps

// A command is taken at a clock edge with start high and busy low. After reset the
// block sweeps its 2048-row state memory, one row a cycle, and holds busy high until
// the sweep is done; threshold writes are taken at any time. An update, and a query
// that finds a free way in valid_mask, reads the set row from the state memory into
// a register and then computes the result in ST_LOOK, where an update also writes
// the row back. A query on a full set goes on to ST_SCAN, since the 16-way victim
// scan runs as two 8-way halves, in ST_LOOK and then in ST_SCAN. Each result shows
// for exactly one cycle with done high, in the cycle after the last compute cycle;
// the receiver cannot stall it, and the next command may be taken in that same cycle.
module phase_adaptive_rrip_lfu_replacement (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       operation,
    input  logic [10:0]                set_index,
    input  logic [3:0]                 way,
    input  logic                       hit,
    input  logic [15:0]                valid_mask,
    input  logic                       cfg_write,
    input  logic [5:0]                 cfg_data,
    output logic                       done,
    output logic [3:0]                 victim_way,
    output logic                       reuse_phase
);

    parl_pkg::state_t                  state_reg, state_next;
    logic [parl_pkg::SET_W-1:0]        clr_cnt_reg;
    logic [parl_pkg::THR_W-1:0]        thr_reg;
    logic                              done_reg;
    logic                              op_reg;
    logic [parl_pkg::SET_W-1:0]        set_reg;
    logic [parl_pkg::WAY_W-1:0]        way_reg;
    logic                              hit_reg;
    logic [parl_pkg::NUM_WAYS-1:0]     mask_reg;
    parl_pkg::scan_carry_t             carry_reg;
    logic [parl_pkg::WAY_W-1:0]        victim_reg;
    logic                              phase_reg;

    parl_pkg::set_row_t                row_mem [parl_pkg::NUM_SETS];
    parl_pkg::set_row_t                rdata_reg;

    logic                              accept;
    logic                              clr_last;
    logic                              mask_full;
    logic [parl_pkg::WAY_W-1:0]        free_way;
    logic [parl_pkg::HIT_W-1:0]        hits_inc;
    logic [parl_pkg::POS_W:0]          pos_inc;
    logic                              wrap;
    logic                              flag_new;
    parl_pkg::set_row_t                upd_row;
    parl_pkg::scan_carry_t             carry_lo;
    parl_pkg::scan_carry_t             carry_hi;

    logic                              mem_we;
    logic [parl_pkg::SET_W-1:0]        mem_waddr;
    parl_pkg::set_row_t                mem_wdata;
    logic                              res_load;
    logic [parl_pkg::WAY_W-1:0]        res_victim;
    logic                              res_phase;
    logic                              carry_load;

    assign accept    = start && !busy;
    assign clr_last  = (clr_cnt_reg == parl_pkg::SET_W'(parl_pkg::NUM_SETS - 1));
    assign mask_full = &mask_reg;

    // Find the lowest invalid way
    always_comb
    begin
        free_way = '0;
        for (int i = parl_pkg::NUM_WAYS - 1; i >= 0; i--)
        begin
            if (!mask_reg[i])
            begin
                free_way = parl_pkg::WAY_W'(i);
            end
        end
    end

    // Advance the window and apply the hit or fill to the row
    always_comb
    begin
        hits_inc = rdata_reg.hits + parl_pkg::HIT_W'(hit_reg);
        pos_inc  = {1'b0, rdata_reg.pos} + 1'b1;
        wrap     = (pos_inc >= (parl_pkg::POS_W + 1)'(parl_pkg::WINDOW_LEN));
        flag_new = wrap ? (parl_pkg::THR_W'(hits_inc) >= thr_reg) : rdata_reg.high_reuse;

        upd_row            = rdata_reg;
        upd_row.high_reuse = flag_new;
        upd_row.hits       = wrap ? '0 : hits_inc;
        upd_row.pos        = wrap ? '0 : pos_inc[parl_pkg::POS_W-1:0];
        if (hit_reg)
        begin
            if (rdata_reg.ways[way_reg].ru < parl_pkg::RU_W'(parl_pkg::REUSE_LIMIT))
            begin
                upd_row.ways[way_reg].ru = rdata_reg.ways[way_reg].ru + 1'b1;
            end
            upd_row.ways[way_reg].rr = '0;
        end
        else
        begin
            upd_row.ways[way_reg].ru = parl_pkg::RU_W'(1);
            upd_row.ways[way_reg].rr = flag_new ? '0 : parl_pkg::REREF_MAX;
        end
    end

    // Scan the lower ways from the start value, the upper ways from the held carry
    parl_scan u_scan_lo (
        .high_reuse (rdata_reg.high_reuse),
        .carry_in   (parl_pkg::SCAN_INIT),
        .ways       (rdata_reg.ways[parl_pkg::HALF_WAYS-1:0]),
        .base       ('0),
        .carry_out  (carry_lo)
    );

    parl_scan u_scan_hi (
        .high_reuse (rdata_reg.high_reuse),
        .carry_in   (carry_reg),
        .ways       (rdata_reg.ways[parl_pkg::NUM_WAYS-1:parl_pkg::HALF_WAYS]),
        .base       (parl_pkg::WAY_W'(parl_pkg::HALF_WAYS)),
        .carry_out  (carry_hi)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            parl_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = parl_pkg::ST_IDLE;
                end
            end
            parl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = parl_pkg::ST_LOOK;
                end
            end
            parl_pkg::ST_LOOK:
            begin
                if ((op_reg == parl_pkg::OP_QUERY) && mask_full)
                begin
                    state_next = parl_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = parl_pkg::ST_IDLE;
                end
            end
            parl_pkg::ST_SCAN:
            begin
                state_next = parl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = parl_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        busy       = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = set_reg;
        mem_wdata  = upd_row;
        res_load   = 1'b0;
        res_victim = '0;
        res_phase  = rdata_reg.high_reuse;
        carry_load = 1'b0;
        unique case (state_reg)
            parl_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = parl_pkg::reset_row();
            end
            parl_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            parl_pkg::ST_LOOK:
            begin
                if (op_reg == parl_pkg::OP_UPDATE)
                begin
                    mem_we    = 1'b1;
                    res_load  = 1'b1;
                    res_phase = flag_new;
                end
                else if (!mask_full)
                begin
                    res_load   = 1'b1;
                    res_victim = free_way;
                end
                else
                begin
                    carry_load = 1'b1;
                end
            end
            parl_pkg::ST_SCAN:
            begin
                res_load   = 1'b1;
                res_victim = carry_hi.victim;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= parl_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            thr_reg     <= parl_pkg::THR_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_load;
            if (state_reg == parl_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_write)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // Hold the command word, the scan carry and the result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            set_reg  <= set_index[parl_pkg::SET_W-1:0];
            way_reg  <= way;
            hit_reg  <= hit;
            mask_reg <= valid_mask;
        end
        if (carry_load)
        begin
            carry_reg <= carry_lo;
        end
        if (res_load)
        begin
            victim_reg <= res_victim;
            phase_reg  <= res_phase;
        end
    end

    // Set row memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= row_mem[set_index[parl_pkg::SET_W-1:0]];
        end
    end

    assign done        = done_reg;
    assign victim_way  = victim_reg;
    assign reuse_phase = phase_reg;

endmodule
